@@ rtl/cct_pkg.sv @@
package cct_pkg;

   typedef logic [1:0]  action_type;
   typedef logic [3:0]  port_type;
   typedef logic [2:0]  status_type;
   typedef logic [4:0]  limit_type;
   typedef logic [31:0] count_type;

   localparam action_type ACT_ROUTE = 2'd0;
   localparam action_type ACT_SET   = 2'd1;
   localparam action_type ACT_UNSET = 2'd2;

   localparam status_type ST_OK        = 3'd0;
   localparam status_type ST_DROPPED   = 3'd1;
   localparam status_type ST_IN_BUSY   = 3'd2;
   localparam status_type ST_OUT_RANGE = 3'd3;
   localparam status_type ST_OUT_TAKEN = 3'd4;

   localparam limit_type LIMIT_RESET = 5'd16;
   localparam count_type COUNT_MAX   = 32'hFFFF_FFFF;

   // wide enough to hold any port index up to the largest table depth
   localparam int IDX_EXT_W = 9;

endpackage

@@ rtl/cct_if.sv @@
interface cct_req_if;
   import cct_pkg::*;
   logic       valid;
   logic       ready;
   action_type action;
   port_type   in_port;
   port_type   out_port;
   modport source (output valid, action, in_port, out_port, input ready);
   modport sink   (input valid, action, in_port, out_port, output ready);
endinterface

interface cct_rsp_if;
   import cct_pkg::*;
   logic       valid;
   logic       ready;
   logic       forward;
   port_type   routed_port;
   status_type status;
   count_type  drops_seen;
   modport source (output valid, forward, routed_port, status, drops_seen, input ready);
   modport sink   (input valid, forward, routed_port, status, drops_seen, output ready);
endinterface

interface cct_csr_if;
   import cct_pkg::*;
   logic      valid;
   logic      ready;
   limit_type data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ rtl/cct_route_ram.sv @@
module cct_route_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  cct_pkg::port_type  wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output cct_pkg::port_type  rd_data
);
   import cct_pkg::*;

   port_type mem_ff [DEPTH];
   port_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/crossbar_connection_table.sv @@
// crossbar connection table
// req_chan carries one transaction per item: action (route, set, unset),
// in_port and out_port. rsp_chan returns exactly one transaction per item
// with forward, routed_port, status and the running drop count drops_seen.
// csr_chan writes the number of output ports in use; it is always ready and
// the user must write it only while the block is idle; the block does not
// enforce this. the route memory is read and the item enters the decision
// stage at the accepting edge; the decision and table update land in the
// output register when the decision stage advances. the block takes one
// item per cycle while the receiver takes results; a set followed by an
// item on the same input is served by forwarding the last memory write, so
// no bubble. reset clears all connection valid bits, the ownership bits and
// the drop counter, and sets the output count to 16; the route memory itself
// is not cleared. when the receiver stalls, the output register holds its
// result, the decision stage holds any item it has and req_chan.ready stays
// low while it holds one, until the output register is taken.
module crossbar_connection_table #(
   parameter int NUM_INPUTS  = 16,
   parameter int NUM_OUTPUTS = 16
) (
   input  logic      clock,
   input  logic      reset,
   cct_req_if.sink   req_chan,
   cct_rsp_if.source rsp_chan,
   cct_csr_if.sink   csr_chan
);
   import cct_pkg::*;

   localparam int IN_AW  = $clog2(NUM_INPUTS);
   localparam int OUT_AW = $clog2(NUM_OUTPUTS);

   // configuration
   limit_type limit_ff, limit_in;

   // decision stage
   logic       s1_vld_ff, s1_vld_in;
   action_type s1_act_ff;
   port_type   s1_ip_ff;
   port_type   s1_op_ff;
   logic       fwd_hit_ff;
   port_type   fwd_port_ff;

   // table state
   logic [NUM_INPUTS-1:0]  route_vld_ff, route_vld_in;
   logic [NUM_OUTPUTS-1:0] owner_vld_ff, owner_vld_in;
   count_type              drop_ff, drop_in;

   // output register
   logic       rsp_vld_ff, rsp_vld_in;
   logic       rsp_fwd_ff;
   port_type   rsp_port_ff;
   status_type rsp_status_ff;
   count_type  rsp_drops_ff;

   logic                 req_acc;
   logic                 s1_adv;
   logic [IDX_EXT_W-1:0] req_ip_ext;
   logic [IN_AW-1:0]     req_idx;
   logic [IDX_EXT_W-1:0] ip_ext;
   logic [IDX_EXT_W-1:0] op_ext;
   logic [IDX_EXT_W-1:0] cur_ext;
   logic [IN_AW-1:0]     ip_idx;
   logic [OUT_AW-1:0]    op_idx;
   logic [OUT_AW-1:0]    cur_idx;
   logic                 ip_ok;
   logic                 op_ok;
   logic                 in_set;
   logic                 out_range;
   logic                 out_taken;
   port_type             ram_rd;
   port_type             cur_port;
   logic                 do_set;
   logic                 do_unset;
   logic                 res_fwd;
   port_type             res_port;
   status_type           res_status;
   count_type            res_drops;

   assign csr_chan.ready = 1'b1;
   assign limit_in = csr_chan.valid ? csr_chan.data : limit_ff;

   assign s1_adv         = s1_vld_ff && (!rsp_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_vld_ff || s1_adv;
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign s1_vld_in      = req_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_ff);

   assign req_ip_ext = IDX_EXT_W'(req_chan.in_port);
   assign req_idx    = req_ip_ext[IN_AW-1:0];

   cct_route_ram #(
      .DEPTH (NUM_INPUTS),
      .AW    (IN_AW)
   ) u_route_ram (
      .clock   (clock),
      .wr_en   (s1_adv && do_set),
      .wr_addr (ip_idx),
      .wr_data (s1_op_ff),
      .rd_en   (req_acc),
      .rd_addr (req_idx),
      .rd_data (ram_rd)
   );

   // decision on the item held in the decision stage
   assign ip_ext   = IDX_EXT_W'(s1_ip_ff);
   assign op_ext   = IDX_EXT_W'(s1_op_ff);
   assign ip_idx   = ip_ext[IN_AW-1:0];
   assign op_idx   = op_ext[OUT_AW-1:0];
   assign ip_ok    = ip_ext < IDX_EXT_W'(NUM_INPUTS);
   assign op_ok    = op_ext < IDX_EXT_W'(NUM_OUTPUTS);
   assign cur_port = fwd_hit_ff ? fwd_port_ff : ram_rd;
   assign cur_ext  = IDX_EXT_W'(cur_port);
   assign cur_idx  = cur_ext[OUT_AW-1:0];

   assign in_set    = ip_ok && route_vld_ff[ip_idx];
   assign out_range = ({1'b0, s1_op_ff} >= limit_ff) || !op_ok;
   // a programmed output always belongs to a programmed input, so any
   // owner here is another input once the input itself is known free
   assign out_taken = owner_vld_ff[op_idx];

   always_comb begin
      res_fwd    = 1'b0;
      res_port   = '0;
      res_status = ST_OK;
      res_drops  = drop_ff;
      do_set     = 1'b0;
      do_unset   = 1'b0;
      case (s1_act_ff)
         ACT_ROUTE: begin
            if (in_set) begin
               res_fwd  = 1'b1;
               res_port = cur_port;
            end else begin
               res_status = ST_DROPPED;
               if (drop_ff != COUNT_MAX) begin
                  res_drops = drop_ff + 32'd1;
               end
            end
         end
         ACT_SET: begin
            if (!ip_ok) begin
               res_status = ST_OUT_RANGE;
            end else if (in_set) begin
               res_status = ST_IN_BUSY;
            end else if (out_range) begin
               res_status = ST_OUT_RANGE;
            end else if (out_taken) begin
               res_status = ST_OUT_TAKEN;
            end else begin
               do_set = 1'b1;
            end
         end
         ACT_UNSET: begin
            do_unset = in_set;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      route_vld_in = route_vld_ff;
      owner_vld_in = owner_vld_ff;
      drop_in      = drop_ff;
      if (s1_adv) begin
         drop_in = res_drops;
         if (do_set) begin
            route_vld_in[ip_idx] = 1'b1;
            owner_vld_in[op_idx] = 1'b1;
         end
         if (do_unset) begin
            route_vld_in[ip_idx]  = 1'b0;
            owner_vld_in[cur_idx] = 1'b0;
         end
      end
   end

   assign rsp_vld_in = s1_adv ? 1'b1 : ((rsp_vld_ff && rsp_chan.ready) ? 1'b0 : rsp_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         s1_vld_ff    <= 1'b0;
         route_vld_ff <= '0;
         owner_vld_ff <= '0;
         drop_ff      <= '0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         s1_vld_ff    <= s1_vld_in;
         route_vld_ff <= route_vld_in;
         owner_vld_ff <= owner_vld_in;
         drop_ff      <= drop_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_act_ff   <= req_chan.action;
         s1_ip_ff    <= req_chan.in_port;
         s1_op_ff    <= req_chan.out_port;
         // a set retiring this cycle is not yet visible to the memory read
         fwd_hit_ff  <= s1_adv && do_set && (ip_idx == req_idx);
         fwd_port_ff <= s1_op_ff;
      end
      if (s1_adv) begin
         rsp_fwd_ff    <= res_fwd;
         rsp_port_ff   <= res_port;
         rsp_status_ff <= res_status;
         rsp_drops_ff  <= res_drops;
      end
   end

   assign rsp_chan.valid       = rsp_vld_ff;
   assign rsp_chan.forward     = rsp_fwd_ff;
   assign rsp_chan.routed_port = rsp_port_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.drops_seen  = rsp_drops_ff;

endmodule

@@ rtl/cct_checker.sv @@
module cct_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_forward,
   input cct_pkg::port_type    rsp_routed_port,
   input cct_pkg::status_type  rsp_status
);
   import cct_pkg::*;

   // a pending result is never withdrawn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before it was taken");

   a_fwd_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_forward |-> rsp_status == ST_OK)
      else $error("forwarded item carries an error status");

   a_port_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_forward |-> rsp_routed_port == '0)
      else $error("routed port set on a result without forward");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_OUT_TAKEN)
      else $error("status code out of range");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind crossbar_connection_table cct_checker u_cct_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_forward     (rsp_chan.forward),
   .rsp_routed_port (rsp_chan.routed_port),
   .rsp_status      (rsp_chan.status)
);

@@ tb/tb.sv @@
module tb;
   import cct_pkg::*;

   // action code that the block leaves without effect
   localparam action_type ACT_SPARE = 2'd3;

   localparam int NUM_PORTS   = 16;
   localparam int HOLD_CYCLES = 80;
   localparam int QUIET_LIMIT = 2000;
   localparam int PHASE_ITEMS = 216;

   typedef struct packed {
      logic       forward;
      port_type   routed_port;
      status_type status;
      count_type  drops_seen;
   } route_result_type;

   class connection_tracker;
      bit               route_valid [NUM_PORTS];
      port_type         route_port  [NUM_PORTS];
      bit               owner_valid [NUM_PORTS];
      port_type         owner_port  [NUM_PORTS];
      count_type        drop_total;
      limit_type        outputs_in_use;
      route_result_type expected_q[$];
      int unsigned      errors;

      function new();
         foreach (route_valid[i]) begin
            route_valid[i] = 1'b0;
            route_port[i]  = '0;
            owner_valid[i] = 1'b0;
            owner_port[i]  = '0;
         end
         drop_total     = '0;
         outputs_in_use = LIMIT_RESET;
         errors         = 0;
      endfunction

      function int unsigned output_limit();
         return (outputs_in_use > NUM_PORTS) ? NUM_PORTS : outputs_in_use;
      endfunction

      function void note_item(action_type act, port_type ip, port_type op);
         route_result_type r;
         port_type         held;
         r.forward     = 1'b0;
         r.routed_port = '0;
         r.status      = ST_OK;
         case (act)
            ACT_ROUTE: begin
               if (route_valid[ip]) begin
                  r.forward     = 1'b1;
                  r.routed_port = route_port[ip];
               end else begin
                  r.status = ST_DROPPED;
                  if (drop_total != COUNT_MAX) drop_total++;
               end
            end
            ACT_SET: begin
               // refusal order: input busy, then range, then occupied output
               if (route_valid[ip]) r.status = ST_IN_BUSY;
               else if (int'(op) >= output_limit()) r.status = ST_OUT_RANGE;
               else if (owner_valid[op] && owner_port[op] != ip) r.status = ST_OUT_TAKEN;
               else begin
                  route_valid[ip] = 1'b1;
                  route_port[ip]  = op;
                  owner_valid[op] = 1'b1;
                  owner_port[op]  = ip;
               end
            end
            ACT_UNSET: begin
               if (route_valid[ip]) begin
                  held = route_port[ip];
                  if (owner_valid[held] && owner_port[held] == ip) owner_valid[held] = 1'b0;
                  route_valid[ip] = 1'b0;
                  route_port[ip]  = '0;
               end
            end
            default: ;
         endcase
         r.drops_seen = drop_total;
         expected_q.push_back(r);
      endfunction

      function void check_result(logic fwd, port_type rport, status_type st, count_type drops);
         route_result_type e;
         if (expected_q.size() == 0) begin
            $error("result transaction with no item pending");
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (fwd !== e.forward) begin
            $error("forward: expected %0d, actual %0d", e.forward, fwd);
            errors++;
         end
         if (rport !== e.routed_port) begin
            $error("routed_port: expected %0d, actual %0d", e.routed_port, rport);
            errors++;
         end
         if (st !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, st);
            errors++;
         end
         if (drops !== e.drops_seen) begin
            $error("drops_seen: expected %0d, actual %0d", e.drops_seen, drops);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   cct_req_if req_chan ();
   cct_rsp_if rsp_chan ();
   cct_csr_if csr_chan ();

   connection_tracker tracker = new();

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit hold_off_start = 1'b0;

   crossbar_connection_table #(
      .NUM_INPUTS  (NUM_PORTS),
      .NUM_OUTPUTS (NUM_PORTS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         tracker.check_result(rsp_chan.forward, rsp_chan.routed_port,
                              rsp_chan.status, rsp_chan.drops_seen);
   end

   initial begin : receiver
      int unsigned hold_left;
      hold_left      = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_start) begin
            hold_off_start = 1'b0;
            hold_left      = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) ||
             (rsp_chan.valid && rsp_chan.ready) || (csr_chan.valid && csr_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // entered and left at a falling edge; valid stays high into the next item
   task automatic send_item(input action_type act, input port_type ip, input port_type op);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid    <= 1'b0;
         req_chan.action   <= action_type'($urandom_range(3));
         req_chan.in_port  <= port_type'($urandom_range(15));
         req_chan.out_port <= port_type'($urandom_range(15));
         @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.action   <= act;
      req_chan.in_port  <= ip;
      req_chan.out_port <= op;
      do @(posedge clock); while (!req_chan.ready);
      tracker.note_item(act, ip, op);
      @(negedge clock);
   endtask

   task automatic write_limit(input limit_type value);
      req_chan.valid <= 1'b0;
      while (tracker.expected_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      tracker.outputs_in_use = value;
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic run_random(input int unsigned count);
      action_type  act;
      port_type    ip;
      port_type    op;
      int unsigned pick;
      int unsigned lim;
      int unsigned k;
      repeat (count) begin
         pick = $urandom_range(99);
         ip   = port_type'($urandom_range(15));
         op   = port_type'($urandom_range(15));
         lim  = tracker.output_limit();
         if (pick < 45) begin
            act = ACT_ROUTE;
         end else if (pick < 75) begin
            act = ACT_SET;
            // mostly aim at a free input and a free in-range output so connections succeed
            if (pick < 68) begin
               for (k = 0; k < 16 && tracker.route_valid[ip]; k++)
                  ip = port_type'($urandom_range(15));
               if (lim > 0) begin
                  op = port_type'($urandom_range(lim - 1));
                  for (k = 0; k < 16 && tracker.owner_valid[op]; k++)
                     op = port_type'($urandom_range(lim - 1));
               end
            end
         end else if (pick < 95) begin
            act = ACT_UNSET;
         end else begin
            act = ACT_SPARE;
         end
         send_item(act, ip, op);
      end
   endtask

   task automatic run_phase(input limit_type value, input int send_pct, input int stall_pct,
                            input bit hold);
      write_limit(value);
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      if (hold) hold_off_start = 1'b1;
      run_random(PHASE_ITEMS);
   endtask

   initial begin : stimulus
      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.action   = ACT_ROUTE;
      req_chan.in_port  = '0;
      req_chan.out_port = '0;
      csr_chan.valid    = 1'b0;
      csr_chan.data     = LIMIT_RESET;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      write_limit(LIMIT_RESET);
      send_item(ACT_ROUTE, 4'd0, 4'd0);
      send_item(ACT_ROUTE, 4'd15, 4'd15);
      send_item(ACT_SET, 4'd0, 4'd15);
      send_item(ACT_ROUTE, 4'd0, 4'd3);
      send_item(ACT_SET, 4'd0, 4'd3);
      send_item(ACT_SET, 4'd15, 4'd15);
      send_item(ACT_SET, 4'd15, 4'd0);
      send_item(ACT_ROUTE, 4'd15, 4'd0);
      send_item(ACT_SET, 4'd7, 4'd7);
      send_item(ACT_ROUTE, 4'd7, 4'd15);
      send_item(ACT_UNSET, 4'd15, 4'd9);
      send_item(ACT_ROUTE, 4'd15, 4'd0);
      send_item(ACT_SET, 4'd8, 4'd0);
      send_item(ACT_UNSET, 4'd3, 4'd3);
      send_item(ACT_SPARE, 4'd0, 4'd0);
      send_item(ACT_SPARE, 4'd15, 4'd15);

      // lowered output count: stored connections keep forwarding
      write_limit(5'd5);
      send_item(ACT_ROUTE, 4'd0, 4'd0);
      send_item(ACT_SET, 4'd1, 4'd5);
      send_item(ACT_SET, 4'd1, 4'd4);
      send_item(ACT_UNSET, 4'd0, 4'd0);
      send_item(ACT_SET, 4'd2, 4'd15);
      send_item(ACT_ROUTE, 4'd0, 4'd15);

      run_phase(LIMIT_RESET, 0, 0, 1'b0);
      run_phase(5'd1, 48, 0, 1'b0);
      run_phase(5'd0, 0, 48, 1'b0);
      run_phase(5'd31, 35, 35, 1'b0);
      run_phase(5'd8, 0, 0, 1'b1);
      run_phase(5'd3, 0, 48, 1'b0);
      run_phase(LIMIT_RESET, 35, 35, 1'b0);
      run_phase(limit_type'($urandom_range(31)), 48, 0, 1'b0);

      req_chan.valid <= 1'b0;
      while (tracker.expected_q.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
      if (tracker.errors == 0 && tracker.expected_q.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
